FILE: hdl/sha256_stream_hasher_macros.svh
// ----------------------------------------------------------------------------
// sha256 stream hasher assertion macros
// shared property wrappers for the rtl assertions
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256 package
// round constants, initial hash values and shared command types
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int ROUNDS      = 64;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	typedef logic [31:0] word_t;

	localparam word_t INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic word_t round_k(input logic [5:0] t);
		word_t k;
		unique case (t)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
			default: k = '0;
		endcase
		return k;
	endfunction

	// byte source for a buffer write
	typedef enum logic [1:0] {
		BSRC_DATA = 2'd0,
		BSRC_PAD  = 2'd1,
		BSRC_ZERO = 2'd2,
		BSRC_LEN  = 2'd3
	} byte_src_t;

	// controller to datapath
	typedef struct packed {
		logic      buf_wr;      // write one byte into the block buffer
		byte_src_t buf_src;
		logic [5:0] buf_addr;
		logic      count_byte;  // add eight to the bit counter
		logic      load_word;   // load schedule word from buffer bytes
		logic [5:0] rd_addr;    // buffer read address
		logic      blk_start;   // copy chain into working vars
		logic      round_en;    // one compression round
		logic [5:0] round_idx;
		logic      blk_end;     // fold working vars into chain
		logic      msg_reset;   // back to initial values
		logic [2:0] out_sel;
	} dp_cmd_t;

	typedef struct packed {
		word_t digest;
	} dp_sts_t;

endpackage

FILE: hdl/sha256_ram.sv
// ----------------------------------------------------------------------------
// sha256 generic ram
// single write port, single registered read port
// ----------------------------------------------------------------------------
module sha256_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

FILE: hdl/sha256_datapath.sv
// ----------------------------------------------------------------------------
// sha256 datapath
// block buffer, bit counter, schedule window, round unit and chaining words
// ----------------------------------------------------------------------------
module sha256_datapath
	import sha256_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic [7:0] data_byte,
	input  dp_cmd_t cmd,
	output dp_sts_t sts
);

	logic [63:0] bits_q;
	word_t       chain_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [7:0]  wr_byte;
	logic [7:0]  rd_byte;
	logic [7:0]  len_byte;
	logic        ld_q;
	word_t       acc_q;
	logic [1:0]  nb_q;

	// length byte at buffer position 56..63, big endian
	always_comb begin
		len_byte = bits_q[63:56];
		unique case (cmd.buf_addr[2:0])
			3'd0: len_byte = bits_q[63:56];
			3'd1: len_byte = bits_q[55:48];
			3'd2: len_byte = bits_q[47:40];
			3'd3: len_byte = bits_q[39:32];
			3'd4: len_byte = bits_q[31:24];
			3'd5: len_byte = bits_q[23:16];
			3'd6: len_byte = bits_q[15:8];
			3'd7: len_byte = bits_q[7:0];
			default: len_byte = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.buf_src)
			BSRC_DATA: wr_byte = data_byte;
			BSRC_PAD:  wr_byte = PAD_BYTE;
			BSRC_ZERO: wr_byte = 8'h00;
			BSRC_LEN:  wr_byte = len_byte;
			default:   wr_byte = 8'h00;
		endcase
	end

	sha256_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_buf (
		.clk    (clk),
		.wr_en  (cmd.buf_wr),
		.wr_addr(cmd.buf_addr),
		.wr_data(wr_byte),
		.rd_addr(cmd.rd_addr),
		.rd_data(rd_byte)
	);

	// round logic
	word_t w_new, w_cur, s0, s1, t1, t2, w2, w15;
	always_comb begin
		w2  = w_q[14];
		w15 = w_q[1];
		s1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
		s0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
		w_new = s1 + w_q[9] + s0 + w_q[0];
		w_cur = (cmd.round_idx < 6'd16) ? w_q[0] : w_new;
		t1 = v_q[7] + ({v_q[4][5:0], v_q[4][31:6]} ^ {v_q[4][10:0], v_q[4][31:11]}
			^ {v_q[4][24:0], v_q[4][31:25]}) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ round_k(cmd.round_idx) + w_cur;
		t2 = ({v_q[0][1:0], v_q[0][31:2]} ^ {v_q[0][12:0], v_q[0][31:13]}
			^ {v_q[0][21:0], v_q[0][31:22]})
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// byte position within the word being assembled, wraps once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q <= 2'd0;
		end else if (ld_q) begin
			nb_q <= nb_q + 2'd1;
		end
	end

	// w_q acts as a shift window: w_q[0] is the current word for round indices below 16
	always_ff @(posedge clk) begin
		ld_q <= cmd.load_word;
		if (ld_q) begin
			acc_q <= {acc_q[23:0], rd_byte};
			if (nb_q == 2'd3) begin
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= {acc_q[23:0], rd_byte};
			end
		end
		if (cmd.blk_start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= chain_q[i];
		end else if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_H[i];
		end else if (cmd.msg_reset) begin
			bits_q <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= INIT_H[i];
		end else begin
			if (cmd.count_byte) bits_q <= bits_q + 64'd8;
			if (cmd.blk_end) begin
				for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + v_q[i];
			end
		end
	end

	assign sts.digest = chain_q[cmd.out_sel];

endmodule

FILE: hdl/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256 controller
// stream handshake, padding sequencer and compression sequencing
// ----------------------------------------------------------------------------
module sha256_ctrl
	import sha256_pkg::*;
`include "sha256_stream_hasher_macros.svh"
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_byte,
	input  logic    in_last,
	output logic    in_ready,
	output logic    out_valid,
	output logic    out_last,
	input  logic    out_ready,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_ROUND, ST_FOLD, ST_PAD, ST_OUT
	} state_t;

	state_t     state_q;
	logic [5:0] fill_q;
	logic [6:0] cnt_q;      // load byte index or round index
	logic       fin_q;      // finalising
	logic       lenblk_q;   // current padding block ends in the length
	logic       last_q;     // pending last after byte fill
	logic [2:0] osel_q;

	// no new transaction while a last is still waiting for its pad marker
	assign in_ready  = (state_q == ST_IDLE) && !last_q;
	assign out_valid = (state_q == ST_OUT);
	assign out_last  = out_valid && (osel_q == 3'd7);

	logic acc;
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.out_sel   = osel_q;
		cmd.buf_addr  = fill_q;
		cmd.rd_addr   = cnt_q[5:0];
		cmd.round_idx = cnt_q[5:0];
		unique case (state_q)
			ST_IDLE: begin
				if (acc && in_byte) begin
					cmd.buf_wr = 1'b1;
					cmd.buf_src = BSRC_DATA;
					cmd.count_byte = 1'b1;
				end else if (acc && in_last) begin
					cmd.buf_wr = 1'b1;
					cmd.buf_src = BSRC_PAD;
				end else if (last_q) begin
					cmd.buf_wr = 1'b1;
					cmd.buf_src = BSRC_PAD;
				end
			end
			ST_PAD: begin
				cmd.buf_wr = 1'b1;
				cmd.buf_src = (lenblk_q && fill_q >= LEN_POS) ? BSRC_LEN : BSRC_ZERO;
			end
			ST_LOAD: begin
				cmd.load_word = (cnt_q < 7'd64);
				if (cnt_q == 7'd65) cmd.blk_start = 1'b1;
			end
			ST_ROUND: cmd.round_en = 1'b1;
			ST_FOLD:  cmd.blk_end = 1'b1;
			ST_OUT:   cmd.msg_reset = out_ready && (osel_q == 3'd7);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			lenblk_q <= 1'b0;
			last_q <= 1'b0;
			osel_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && in_byte) begin
						fill_q <= fill_q + 6'd1;
						last_q <= in_last;
						if (fill_q == 6'd63) begin
							cnt_q <= '0;
							state_q <= ST_LOAD;
						end else if (in_last) begin
							state_q <= ST_IDLE;
						end
					end else if (acc && in_last) begin
						// pad marker written at fill position
						fin_q <= 1'b1;
						lenblk_q <= (fill_q < LEN_POS);
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							cnt_q <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_PAD;
						end
					end else if (last_q) begin
						// byte and last together: pad marker follows the byte
						last_q <= 1'b0;
						fin_q <= 1'b1;
						lenblk_q <= (fill_q < LEN_POS);
						fill_q <= fill_q + 6'd1;
						state_q <= (fill_q == 6'd63) ? ST_LOAD : ST_PAD;
						cnt_q <= '0;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						cnt_q <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd65) begin
						cnt_q <= '0;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 7'd1;
					if (cnt_q == 7'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					fill_q <= '0;
					cnt_q <= '0;
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (lenblk_q) begin
						osel_q <= '0;
						state_q <= ST_OUT;
					end else begin
						lenblk_q <= 1'b1;
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						osel_q <= osel_q + 3'd1;
						if (osel_q == 3'd7) begin
							fin_q <= 1'b0;
							lenblk_q <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SHA_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid && !cmd.round_en, "ready while busy")
	`SHA_ASSERT_NEXT(a_fold_after_round, clk, arst_n, state_q == ST_ROUND && cnt_q == 7'd63, state_q == ST_FOLD, "round count slip")
	`SHA_ASSERT_IMP(a_last_eighth, clk, arst_n, out_last, osel_q == 3'd7, "word_last misplaced")
	`SHA_ASSERT_IMP(a_out_finalised, clk, arst_n, out_valid, fin_q && lenblk_q, "digest before length block")

endmodule

FILE: hdl/sha256_stream_hasher.sv
// sha256 stream hasher: one byte transaction per accepted input
// a full block: buffer fill, schedule load, 64 rounds (one round a cycle) and one fold
// finalisation writes the padding bytes one a cycle, then one or two blocks, then eight words
// arst_n clears the controller and loads the initial hash values; buffer contents stay undefined
// ----------------------------------------------------------------------------
// sha256 stream hasher top level
// byte stream in, eight 32-bit digest words out
// ----------------------------------------------------------------------------
module sha256_stream_hasher
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tuser,   // byte_valid
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // digest_word
	output logic        m_tlast    // word_last
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// controller runs the padding and round sequence
	sha256_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tuser),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_last (m_tlast),
		.out_ready(m_tready),
		.cmd      (cmd)
	);

	// datapath holds buffer, schedule, chain and bit count
	sha256_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_byte(s_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

	assign m_tdata = sts.digest;

endmodule
